// File: rtl/core/thad_pkg.sv
// ----------------------------------------------------------------------------
// thad_pkg
// Shared constants, ROM and side-band types for the thermistor to PWM pipeline.
// ----------------------------------------------------------------------------
package thad_pkg;

    localparam int TABLE_ENTRIES  = 20;
    localparam int ADC_SHIFT      = 10;
    localparam int PWM_SHIFT      = 10;
    localparam int HIT_W          = $clog2(TABLE_ENTRIES);

    localparam logic [10:0] PWM_FULL_SCALE = 11'd1024;

    localparam logic [2:0] CFG_SUPPLY_MV   = 3'd0;
    localparam logic [2:0] CFG_PULLUP_OHMS = 3'd1;
    localparam logic [2:0] CFG_TEMP_LOW_F  = 3'd2;
    localparam logic [2:0] CFG_TEMP_HIGH_F = 3'd3;
    localparam logic [2:0] CFG_OUT_HIGH_MV = 3'd4;

    typedef struct packed {
        logic ch;
        logic open_div;
    } div_side_t;

    typedef struct packed {
        logic              ch;
        logic              interp;
        logic signed [9:0] degf;
    } lut_side_t;

    typedef struct packed {
        logic              ch;
        logic              below;
        logic              above;
        logic signed [9:0] degf;
    } map_side_t;

    typedef struct packed {
        logic              ch;
        logic signed [9:0] degf;
        logic [12:0]       tmv;
    } pwm_side_t;

    function automatic logic [16:0] rom_ohms(input logic [HIT_W-1:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd96044;
            5'd1:    v = 17'd53674;
            5'd2:    v = 17'd26386;
            5'd3:    v = 17'd14822;
            5'd4:    v = 17'd9124;
            5'd5:    v = 17'd5244;
            5'd6:    v = 17'd3277;
            5'd7:    v = 17'd2108;
            5'd8:    v = 17'd1392;
            5'd9:    v = 17'd941;
            5'd10:   v = 17'd650;
            5'd11:   v = 17'd458;
            5'd12:   v = 17'd329;
            5'd13:   v = 17'd240;
            5'd14:   v = 17'd178;
            5'd15:   v = 17'd134;
            5'd16:   v = 17'd102;
            5'd17:   v = 17'd78;
            5'd18:   v = 17'd61;
            5'd19:   v = 17'd48;
            default: v = 17'd48;
        endcase
        return v;
    endfunction

    function automatic logic signed [9:0] rom_degf(input logic [HIT_W-1:0] idx);
        logic signed [9:0] v;
        case (idx)
            5'd0:    v = -10'sd40;
            5'd1:    v = -10'sd22;
            5'd2:    v = -10'sd4;
            5'd3:    v = 10'sd14;
            5'd4:    v = 10'sd32;
            5'd5:    v = 10'sd50;
            5'd6:    v = 10'sd68;
            5'd7:    v = 10'sd86;
            5'd8:    v = 10'sd104;
            5'd9:    v = 10'sd122;
            5'd10:   v = 10'sd140;
            5'd11:   v = 10'sd158;
            5'd12:   v = 10'sd176;
            5'd13:   v = 10'sd194;
            5'd14:   v = 10'sd212;
            5'd15:   v = 10'sd230;
            5'd16:   v = 10'sd248;
            5'd17:   v = 10'sd266;
            5'd18:   v = 10'sd284;
            5'd19:   v = 10'sd302;
            default: v = 10'sd302;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/thad_div.sv
// ----------------------------------------------------------------------------
// thad_div
// Pipelined restoring divider, one quotient bit per stage, with side-band.
// ----------------------------------------------------------------------------
module thad_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] out_side
);

    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic          vld_reg  [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] n_prev;
        logic [NW-1:0] q_prev;
        logic [DW-1:0] r_prev;
        logic [DW-1:0] d_prev;
        logic [SW-1:0] s_prev;
        logic          v_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign n_prev = num;
            assign q_prev = '0;
            assign r_prev = '0;
            assign d_prev = den;
            assign s_prev = side;
            assign v_prev = in_valid;
        end
        else
        begin : g_next
            assign n_prev = num_reg[k-1];
            assign q_prev = quo_reg[k-1];
            assign r_prev = rem_reg[k-1];
            assign d_prev = den_reg[k-1];
            assign s_prev = side_reg[k-1];
            assign v_prev = vld_reg[k-1];
        end

        assign trial = {r_prev, n_prev[NW-1]};
        assign ge    = trial >= {1'b0, d_prev};
        assign diff  = trial - {1'b0, d_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= {n_prev[NW-2:0], 1'b0};
                quo_reg[k]  <= {q_prev[NW-2:0], ge};
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                den_reg[k]  <= d_prev;
                side_reg[k] <= s_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

// File: rtl/core/thad_lut.sv
// ----------------------------------------------------------------------------
// thad_lut
// Resistance ROM search; sets up the interpolation division.
// ----------------------------------------------------------------------------
module thad_lut (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [29:0]         res,
    input  thad_pkg::div_side_t side,
    output logic                out_valid,
    output logic [21:0]         num,
    output logic [16:0]         den,
    output thad_pkg::lut_side_t out_side
);

    logic                          found;
    logic [thad_pkg::HIT_W-1:0]    hit;
    logic [thad_pkg::HIT_W-1:0]    prev;
    logic [16:0]                   y1;
    logic [16:0]                   y2;
    logic [16:0]                   dy;
    logic                          exact;
    thad_pkg::lut_side_t           s_next;

    logic                          vld_reg;
    logic [21:0]                   num_reg;
    logic [16:0]                   den_reg;
    thad_pkg::lut_side_t           side_reg;

    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int i = thad_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if ({13'd0, thad_pkg::rom_ohms(thad_pkg::HIT_W'(i))} <= res)
            begin
                found = 1'b1;
                hit   = thad_pkg::HIT_W'(i);
            end
        end
        prev  = hit - 1'b1;
        y1    = thad_pkg::rom_ohms(prev);
        y2    = thad_pkg::rom_ohms(hit);
        dy    = y1 - res[16:0];
        exact = {13'd0, y2} == res;

        s_next.ch     = side.ch;
        s_next.interp = 1'b0;
        if (side.open_div)
            s_next.degf = thad_pkg::rom_degf('0);
        else if (!found)
            s_next.degf = thad_pkg::rom_degf(thad_pkg::HIT_W'(thad_pkg::TABLE_ENTRIES - 1));
        else if (hit == '0 || exact)
            s_next.degf = thad_pkg::rom_degf(hit);
        else
        begin
            s_next.degf   = thad_pkg::rom_degf(prev);
            s_next.interp = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= ({5'd0, dy} << 4) + ({5'd0, dy} << 1);
            den_reg  <= y1 - y2;
            side_reg <= s_next;
        end
    end

    assign out_valid = vld_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/core/thermistor_adc_to_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_pwm_duty_top
// Thermistor ADC sample to temperature, target voltage and PWM compare count.
// ----------------------------------------------------------------------------
// Input beat: adc_code and channel on in_valid, held back by in_stall.
// Result beat: channel_out, temperature_f, target_mv and pwm_count on
// out_valid; the receiver holds it with out_stall.
// One result per input, in order. Each sample passes through four
// pipelined dividers (resistance 30 stages, interpolation 22, mapping 22,
// PWM scaling 23) plus seven register stages. A new sample may enter every
// cycle while in_stall is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, written
// while the pipeline is empty; cfg_ready is always high.
// Reset empties the pipeline and loads the register defaults.
// out_stall with a result waiting freezes the whole pipeline and raises
// in_stall in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module thermistor_adc_to_pwm_duty_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [9:0]        adc_code,
    input  logic              channel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              channel_out,
    output logic signed [9:0] temperature_f,
    output logic [12:0]       target_mv,
    output logic [10:0]       pwm_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [16:0]       cfg_data
);

    logic [12:0]       supply_reg;
    logic [16:0]       pullup_reg;
    logic signed [9:0] low_reg;
    logic signed [9:0] high_reg;
    logic [12:0]       ohigh_reg;

    logic en;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= 13'd3300;
            pullup_reg <= 17'd2490;
            low_reg    <= 10'sd32;
            high_reg   <= 10'sd302;
            ohigh_reg  <= 13'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                thad_pkg::CFG_SUPPLY_MV:   supply_reg <= cfg_data[12:0];
                thad_pkg::CFG_PULLUP_OHMS: pullup_reg <= cfg_data;
                thad_pkg::CFG_TEMP_LOW_F:  low_reg    <= signed'(cfg_data[9:0]);
                thad_pkg::CFG_TEMP_HIGH_F: high_reg   <= signed'(cfg_data[9:0]);
                thad_pkg::CFG_OUT_HIGH_MV: ohigh_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // sample millivolts
    logic [22:0] prod_a;
    logic        a_vld_reg;
    logic [12:0] a_smv_reg;
    logic        a_ch_reg;

    assign prod_a = {13'd0, adc_code} * {10'd0, supply_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_smv_reg <= prod_a[22:thad_pkg::ADC_SHIFT];
            a_ch_reg  <= channel;
        end
    end

    // divider operands for resistance
    logic                b_vld_reg;
    logic [29:0]         b_num_reg;
    logic [12:0]         b_den_reg;
    thad_pkg::div_side_t b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_num_reg           <= {13'd0, pullup_reg} * {17'd0, a_smv_reg};
            b_den_reg           <= supply_reg - a_smv_reg;
            b_side_reg.ch       <= a_ch_reg;
            b_side_reg.open_div <= a_smv_reg >= supply_reg;
        end
    end

    logic                d1_vld;
    logic [29:0]         d1_quo;
    thad_pkg::div_side_t d1_side;

    thad_div #(.NW(30), .DW(13), .SW($bits(thad_pkg::div_side_t))) u_div_res (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b_vld_reg),
        .num      (b_num_reg),
        .den      (b_den_reg),
        .side     (b_side_reg),
        .out_valid(d1_vld),
        .quo      (d1_quo),
        .out_side (d1_side)
    );

    logic                l_vld;
    logic [21:0]         l_num;
    logic [16:0]         l_den;
    thad_pkg::lut_side_t l_side;

    thad_lut u_lut (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d1_vld),
        .res      (d1_quo),
        .side     (d1_side),
        .out_valid(l_vld),
        .num      (l_num),
        .den      (l_den),
        .out_side (l_side)
    );

    logic                d2_vld;
    logic [21:0]         d2_quo;
    thad_pkg::lut_side_t d2_side;

    thad_div #(.NW(22), .DW(17), .SW($bits(thad_pkg::lut_side_t))) u_div_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (l_vld),
        .num      (l_num),
        .den      (l_den),
        .side     (l_side),
        .out_valid(d2_vld),
        .quo      (d2_quo),
        .out_side (d2_side)
    );

    // temperature and mapping compares
    logic signed [9:0]  degf;
    logic signed [10:0] diff_m;
    logic signed [10:0] span_m;

    // temperature rises as resistance falls between entries
    assign degf   = d2_side.interp ? d2_side.degf + signed'({5'd0, d2_quo[4:0]})
                                   : d2_side.degf;
    assign diff_m = 11'(degf) - 11'(low_reg);
    assign span_m = 11'(high_reg) - 11'(low_reg);

    logic             m1_vld_reg;
    thad_pkg::map_side_t m1_side_reg;
    logic [8:0]       m1_diff_reg;
    logic [9:0]       m1_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_vld_reg <= 1'b0;
        else if (en)
            m1_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg.ch    <= d2_side.ch;
            m1_side_reg.degf  <= degf;
            m1_side_reg.below <= degf <= low_reg;
            m1_side_reg.above <= degf >= high_reg;
            m1_diff_reg       <= diff_m[8:0];
            m1_span_reg       <= span_m[9:0];
        end
    end

    logic                m2_vld_reg;
    thad_pkg::map_side_t m2_side_reg;
    logic [21:0]         m2_num_reg;
    logic [9:0]          m2_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_vld_reg <= 1'b0;
        else if (en)
            m2_vld_reg <= m1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_side_reg <= m1_side_reg;
            m2_num_reg  <= {13'd0, m1_diff_reg} * {9'd0, ohigh_reg};
            m2_span_reg <= m1_span_reg;
        end
    end

    logic                d3_vld;
    logic [21:0]         d3_quo;
    thad_pkg::map_side_t d3_side;

    thad_div #(.NW(22), .DW(10), .SW($bits(thad_pkg::map_side_t))) u_div_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (m2_vld_reg),
        .num      (m2_num_reg),
        .den      (m2_span_reg),
        .side     (m2_side_reg),
        .out_valid(d3_vld),
        .quo      (d3_quo),
        .out_side (d3_side)
    );

    // target voltage
    logic [12:0] tmv;

    always_comb
    begin
        if (d3_side.below)
            tmv = '0;
        else if (d3_side.above || d3_quo >= {9'd0, ohigh_reg})
            tmv = ohigh_reg;
        else
            tmv = d3_quo[12:0];
    end

    logic                t_vld_reg;
    thad_pkg::pwm_side_t t_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_vld_reg <= 1'b0;
        else if (en)
            t_vld_reg <= d3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_side_reg.ch   <= d3_side.ch;
            t_side_reg.degf <= d3_side.degf;
            t_side_reg.tmv  <= tmv;
        end
    end

    logic                d4_vld;
    logic [22:0]         d4_quo;
    thad_pkg::pwm_side_t d4_side;

    thad_div #(.NW(23), .DW(13), .SW($bits(thad_pkg::pwm_side_t))) u_div_pwm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (t_vld_reg),
        .num      ({t_side_reg.tmv, {thad_pkg::PWM_SHIFT{1'b0}}}),
        .den      (supply_reg),
        .side     (t_side_reg),
        .out_valid(d4_vld),
        .quo      (d4_quo),
        .out_side (d4_side)
    );

    // result register
    logic              o_vld_reg;
    logic              o_ch_reg;
    logic signed [9:0] o_degf_reg;
    logic [12:0]       o_tmv_reg;
    logic [10:0]       o_pwm_reg;
    logic [10:0]       pwm_next;

    assign pwm_next = (supply_reg == '0 || d4_quo >= {12'd0, thad_pkg::PWM_FULL_SCALE})
                      ? thad_pkg::PWM_FULL_SCALE : d4_quo[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= d4_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_ch_reg   <= d4_side.ch;
            o_degf_reg <= d4_side.degf;
            o_tmv_reg  <= d4_side.tmv;
            o_pwm_reg  <= pwm_next;
        end
    end

    assign out_valid     = o_vld_reg;
    assign channel_out   = o_ch_reg;
    assign temperature_f = o_degf_reg;
    assign target_mv     = o_tmv_reg;
    assign pwm_count     = o_pwm_reg;

endmodule

// File: rtl/core/thad_chk.sv
// ----------------------------------------------------------------------------
// thad_chk
// Port-level checks for the thermistor to PWM pipeline.
// ----------------------------------------------------------------------------
module thad_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [9:0]        adc_code,
    input logic              channel,
    input logic              out_valid,
    input logic              out_stall,
    input logic              channel_out,
    input logic signed [9:0] temperature_f,
    input logic [12:0]       target_mv,
    input logic [10:0]       pwm_count,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [2:0]        cfg_index,
    input logic [16:0]       cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped under stall");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while pipeline frozen");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pwm_count <= 11'd1024)
        else $error("pwm count above full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_f >= -10'sd40 && temperature_f <= 10'sd302)
        else $error("temperature outside table");

endmodule

bind thermistor_adc_to_pwm_duty_top thad_chk u_thad_chk (.*);

// File: tb/thermistor_adc_to_pwm_duty_top_tb.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_pwm_duty_top_tb
// Drives ADC samples through the thermistor to PWM pipeline under several
// register settings and idling patterns, and checks every result beat
// against an in-bench predictor of resistance, interpolation and scaling.
// ----------------------------------------------------------------------------
module thermistor_adc_to_pwm_duty_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ch;
        logic signed [9:0] degf;
        logic [12:0]       tmv;
        logic [10:0]       pwm;
    } duty_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [9:0]        adc_code;
    logic              channel;
    logic              out_valid;
    logic              out_stall;
    logic              channel_out;
    logic signed [9:0] temperature_f;
    logic [12:0]       target_mv;
    logic [10:0]       pwm_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [16:0]       cfg_data;

    longint supply_mv, pullup_ohms, low_f, high_f, out_high_mv;
    duty_t  duty_q[$];
    int     errors;
    longint cycles;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_cycles;

    thermistor_adc_to_pwm_duty_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint lookup_degf(bit open_div, longint res);
        longint y1, y2, x1, x2;
        int hit;
        hit = -1;
        if (open_div)
            return -40;
        for (int i = 0; i < thad_pkg::TABLE_ENTRIES; i++)
            if (hit < 0 && longint'(thad_pkg::rom_ohms(thad_pkg::HIT_W'(i))) <= res)
                hit = i;
        if (hit < 0)
            return 302;
        if (hit == 0 || longint'(thad_pkg::rom_ohms(thad_pkg::HIT_W'(hit))) == res)
            return longint'(thad_pkg::rom_degf(thad_pkg::HIT_W'(hit)));
        y1 = longint'(thad_pkg::rom_ohms(thad_pkg::HIT_W'(hit - 1)));
        y2 = longint'(thad_pkg::rom_ohms(thad_pkg::HIT_W'(hit)));
        x1 = longint'(thad_pkg::rom_degf(thad_pkg::HIT_W'(hit - 1)));
        x2 = longint'(thad_pkg::rom_degf(thad_pkg::HIT_W'(hit)));
        return x1 - ((y1 - res) * (x1 - x2)) / (y1 - y2);
    endfunction

    function automatic duty_t predict_duty(logic [9:0] code, logic ch);
        duty_t  r;
        longint smv, res, degf, tmv, pwm, t;
        bit     open_div;
        smv = (longint'(code) * supply_mv) / 1024;
        open_div = smv >= supply_mv;
        res = open_div ? 0 : (pullup_ohms * smv) / (supply_mv - smv);
        degf = lookup_degf(open_div, res);
        if (degf <= low_f)
            tmv = 0;
        else if (degf >= high_f)
            tmv = out_high_mv;
        else
        begin
            t = ((degf - low_f) * out_high_mv) / (high_f - low_f);
            tmv = t >= out_high_mv ? out_high_mv : (t <= 0 ? 0 : t);
        end
        if (supply_mv == 0)
            pwm = 1024;
        else
        begin
            pwm = (tmv * 1024) / supply_mv;
            if (pwm >= 1024)
                pwm = 1024;
        end
        r.ch = ch;
        r.degf = degf[9:0];
        r.tmv = tmv[12:0];
        r.pwm = pwm[10:0];
        return r;
    endfunction

    // receiver stall: random, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        duty_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {channel_out, temperature_f, target_mv, pwm_count};
            if (duty_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat %p", $time, got);
            end
            else
            begin
                want = duty_q.pop_front();
                if (got.ch !== want.ch)
                    $display("%0t: channel_out exp %0d got %0d", $time, want.ch, got.ch);
                if (got.degf !== want.degf)
                    $display("%0t: temperature_f exp %0d got %0d", $time,
                             want.degf, got.degf);
                if (got.tmv !== want.tmv)
                    $display("%0t: target_mv exp %0d got %0d", $time, want.tmv, got.tmv);
                if (got.pwm !== want.pwm)
                    $display("%0t: pwm_count exp %0d got %0d", $time, want.pwm, got.pwm);
                if (got !== want)
                    errors++;
            end
        end
    end

    task automatic send_sample(logic [9:0] code, logic ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        channel <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        duty_q.push_back(predict_duty(code, ch));
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (duty_q.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[16:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            thad_pkg::CFG_SUPPLY_MV:   supply_mv = val & 16'h1FFF;
            thad_pkg::CFG_PULLUP_OHMS: pullup_ohms = val & 17'h1FFFF;
            thad_pkg::CFG_TEMP_LOW_F:  low_f = longint'($signed(val[9:0]));
            thad_pkg::CFG_TEMP_HIGH_F: high_f = longint'($signed(val[9:0]));
            thad_pkg::CFG_OUT_HIGH_MV: out_high_mv = val & 16'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint s, longint p, longint lo, longint hi, longint o);
        drain();
        write_reg(thad_pkg::CFG_SUPPLY_MV, s);
        write_reg(thad_pkg::CFG_PULLUP_OHMS, p);
        write_reg(thad_pkg::CFG_TEMP_LOW_F, lo);
        write_reg(thad_pkg::CFG_TEMP_HIGH_F, hi);
        write_reg(thad_pkg::CFG_OUT_HIGH_MV, o);
        cfg_valid <= 1'b0;
    endtask

    // end codes and a spread across the range
    task automatic test_directed;
        int codes [20] = '{0, 1, 1023, 1022, 512, 511, 768, 256, 900, 1000, 100, 50,
                           10, 3, 2, 700, 820, 950, 600, 400};
        foreach (codes[i])
            send_sample(codes[i][9:0], i[0]);
        send_sample(10'h3FF, 1'b1);
        send_sample(10'h000, 1'b0);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_sample(10'($urandom_range(1023)), 1'($urandom_range(1)));
    endtask

    task automatic test_idling;
        send_idle_pct = 0;   stall_pct = 0;  test_random(200);
        send_idle_pct = 84;  stall_pct = 0;  test_random(120);
        send_idle_pct = 0;   stall_pct = 84; test_random(120);
        send_idle_pct = 10;  stall_pct = 10; test_random(200);
        send_idle_pct = 0;   stall_pct = 0;
    endtask

    task automatic test_backpressure;
        drain();
        @(negedge clk);
        hold_cycles = 400;
        test_random(200);
        drain();
        test_random(30);
    endtask

    task automatic test_settings;
        set_regs(5000, 100000, -40, 302, 5000);
        test_directed(); test_random(60);
        set_regs(1000, 100, 302, -40, 1);
        test_directed(); test_random(40);
        set_regs(1000, 100000, 100, 101, 5000);
        test_directed(); test_random(40);
        set_regs(2500, 10000, -40, -39, 4000);
        test_random(40);
        set_regs(0, 2490, 32, 302, 1000);
        test_random(20);
        for (int k = 0; k < 4; k++)
        begin
            set_regs($urandom_range(5000, 1000), $urandom_range(100000, 100),
                     $urandom_range(100, 0) - 40, $urandom_range(302, 100),
                     $urandom_range(5000, 1));
            test_random(40);
        end
        set_regs(3300, 2490, 32, 302, 1000);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        adc_code = '0;
        channel = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        supply_mv = 3300;
        pullup_ohms = 2490;
        low_f = 32;
        high_f = 302;
        out_high_mv = 1000;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_idling();
        test_backpressure();
        test_settings();
        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
rtl/core/thad_pkg.sv
rtl/core/thad_div.sv
rtl/core/thad_lut.sv
rtl/core/thermistor_adc_to_pwm_duty_top.sv
rtl/core/thad_chk.sv
tb/thermistor_adc_to_pwm_duty_top_tb.sv
